@@ sv/wpm_pkg.sv @@
// Shared constants, types and helpers for the wildcard pattern matcher.
// No dependencies; imported by wpm_cell and wildcard_pattern_match_core.
package wpm_pkg;

  localparam int PAT_LEN = 32;
  localparam int CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] WILD_ONE = 8'h3F;  // '?'
  localparam logic [CHAR_W-1:0] WILD_ANY = 8'h2A;  // '*'
  localparam logic [CHAR_W-1:0] LOWER_A  = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CHAR   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  // Broadcast control for every cell in the chain.
  typedef struct packed {
    logic clear;    // empty the pattern, restart the subject
    logic append;   // store the byte in the first free cell
    logic restart;  // rebuild the active set from position zero
    logic step;     // advance the active set by one subject byte
  } wpm_ctrl_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= LOWER_A && c <= LOWER_Z) r = c - CASE_OFS;
    return r;
  endfunction

endpackage

@@ sv/wpm_cell.sv @@
// One pattern position of the matcher chain: stored byte, valid flag, active flag.
// Depends on wpm_pkg; instantiated PAT_LEN times by wildcard_pattern_match_core.
module wpm_cell
  import wpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              first_i,       // tied high on position zero
  input  wpm_ctrl_t         ctrl_i,
  input  logic [CHAR_W-1:0] char_i,        // folded byte
  input  logic              left_valid_i,
  input  logic              adv_i,         // advance from the left neighbor
  input  logic              carry_i,       // star closure from the left neighbor
  output logic              valid_o,
  output logic              adv_o,
  output logic              carry_o,
  output logic              end_hit_o      // active and first position past the pattern
);

  logic [CHAR_W-1:0] pat_r;
  logic              star_r, one_r;
  logic              valid_r, valid_nxt;
  logic              act_r, act_nxt;
  logic              load, star_e, valid_e, raw, cl;

  assign load    = ctrl_i.append && left_valid_i && !valid_r;
  // A freshly appended star must already take part in this cycle's closure.
  assign star_e  = load ? (char_i == WILD_ANY) : star_r;
  assign valid_e = load | valid_r;

  assign adv_o = ctrl_i.step && act_r && valid_r && !star_r &&
                 (one_r || pat_r == char_i);

  always_comb begin
    if (ctrl_i.restart) begin
      raw = adv_i;
    end else begin
      raw = (act_r && valid_r && star_r) || adv_i;
    end
  end

  assign cl      = raw || carry_i;
  assign carry_o = cl && valid_e && star_e;

  always_comb begin
    valid_nxt = valid_r;
    if (ctrl_i.clear) begin
      valid_nxt = 1'b0;
    end else if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_comb begin
    act_nxt = act_r;
    if (ctrl_i.clear) begin
      act_nxt = first_i;
    end else if (ctrl_i.restart || ctrl_i.step) begin
      act_nxt = cl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      act_r   <= first_i;
    end else begin
      valid_r <= valid_nxt;
      act_r   <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat_r  <= char_i;
      star_r <= (char_i == WILD_ANY);
      one_r  <= (char_i == WILD_ONE);
    end
  end

  assign valid_o   = valid_r;
  assign end_hit_o = act_r && !valid_r;

endmodule

@@ sv/wildcard_pattern_match_core.sv @@
// Top level of the case-insensitive wildcard matcher: command decode, cell chain,
// overflow flag and result register. Depends on wpm_pkg and wpm_cell.
//
//   channel | ports                                   | moves
//   --------+-----------------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_cmd, in_char_value | one command word per accept
//   out     | out_valid, out_stall, out_matched,       | one result word per finish
//           | out_pattern_overflow                    |
//
// One input word per clock while in_stall is low; every command finishes in the cycle it is accepted.
// The star closure is a ripple through the PAT_LEN cells, like a carry chain.
// Result is registered into out_* when the finish word is accepted, or waits
// in a skid register behind a stalled result.
// Synchronous active-low reset: empty pattern, only position zero active.
// in_stall is the registered skid flag: high only while two results are waiting.
module wildcard_pattern_match_core
  import wpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [CHAR_W-1:0] in_char_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_matched,
  output logic              out_pattern_overflow
);

  logic              in_accept;
  logic [CHAR_W-1:0] char_f;
  wpm_ctrl_t         ctrl;
  logic              finish;

  logic [PAT_LEN-1:0] valid_v, adv_v, carry_v, end_v;

  logic tail_act_r, tail_act_nxt;   // position PAT_LEN: whole pattern consumed
  logic ovf_r, ovf_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic matched_r, pover_r;
  logic skid_matched_r, skid_pover_r;
  logic out_busy;                   // result held through this edge
  logic res_matched;
  logic hit;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign char_f    = fold_case(in_char_value);
  assign out_busy  = out_valid_r && out_stall;

  // Command decode into the broadcast control word.
  always_comb begin
    ctrl   = '0;
    finish = 1'b0;
    if (in_accept) begin
      case (cmd_t'(in_cmd))
        CMD_CLEAR: begin
          ctrl.clear   = 1'b1;
          ctrl.restart = 1'b1;
        end
        CMD_APPEND: begin
          ctrl.append  = 1'b1;
          ctrl.restart = 1'b1;
        end
        CMD_CHAR: begin
          ctrl.step = 1'b1;
        end
        CMD_FINISH: begin
          ctrl.restart = 1'b1;
          finish       = 1'b1;
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  // Cell chain. Position zero is seeded by restart; it has no left neighbor.
  genvar gi;
  generate
    for (gi = 0; gi < PAT_LEN; gi++) begin : g_cell
      logic left_valid, adv_in, carry_in;
      if (gi == 0) begin : g_head
        assign left_valid = 1'b1;
        assign adv_in     = ctrl.restart;
        assign carry_in   = 1'b0;
      end else begin : g_body
        assign left_valid = valid_v[gi-1];
        assign adv_in     = adv_v[gi-1];
        assign carry_in   = carry_v[gi-1];
      end
      wpm_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .first_i      (gi == 0),
        .ctrl_i       (ctrl),
        .char_i       (char_f),
        .left_valid_i (left_valid),
        .adv_i        (adv_in),
        .carry_i      (carry_in),
        .valid_o      (valid_v[gi]),
        .adv_o        (adv_v[gi]),
        .carry_o      (carry_v[gi]),
        .end_hit_o    (end_v[gi])
      );
    end
  endgenerate

  // Only the first position past the pattern can be active without a byte,
  // so the end-of-pattern flag is a plain OR over the chain plus the tail.
  assign hit         = (|end_v) || tail_act_r;
  assign res_matched = hit && !ovf_r;

  always_comb begin
    tail_act_nxt = tail_act_r;
    if (ctrl.clear) begin
      tail_act_nxt = 1'b0;
    end else if (ctrl.restart || ctrl.step) begin
      tail_act_nxt = adv_v[PAT_LEN-1] || carry_v[PAT_LEN-1];
    end
  end

  // Overflow: append with every cell already holding a byte.
  always_comb begin
    ovf_nxt = ovf_r;
    if (ctrl.clear) begin
      ovf_nxt = 1'b0;
    end else if (ctrl.append && valid_v[PAT_LEN-1]) begin
      ovf_nxt = 1'b1;
    end
  end

  // Output word: held while stalled, refilled from the skid first, then from
  // a new finish. A finish behind a held word parks in the skid.
  always_comb begin
    out_valid_nxt = 1'b0;
    if (out_busy || skid_valid_r || finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign skid_valid_nxt = out_busy && (skid_valid_r || finish);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_act_r   <= 1'b0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      tail_act_r   <= tail_act_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_busy) begin
      if (skid_valid_r) begin
        matched_r <= skid_matched_r;
        pover_r   <= skid_pover_r;
      end else if (finish) begin
        matched_r <= res_matched;
        pover_r   <= ovf_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_busy && finish) begin
      skid_matched_r <= res_matched;
      skid_pover_r   <= ovf_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_matched          = matched_r;
  assign out_pattern_overflow = pover_r;

endmodule
